// ----- design/adcema_pkg.sv -----
package adcema_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_SHIFT_K     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_VOLT_GAIN   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_OFFSET = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_GAIN   = 3'd4;

   localparam int SHIFT_W = 4;
   localparam int WIN_W   = 7;
   localparam int WIN_LIMIT = 127;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET     = 4'd7;
   localparam logic [31:0]        VOLT_GAIN_RESET = 32'h0100_0000;
   localparam int                 WIN_RESET_MAX   = 64;

   // accumulator headroom above the sample width, largest shift setting
   localparam int ACC_HEADROOM     = 15;
   localparam int ACC_RESET_SHIFT  = 7;
   localparam int TEMP_START_LEVEL = 1600;

   localparam logic [31:0] PHYS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] PHYS_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [SHIFT_W-1:0] shift_k;
      logic [WIN_W-1:0]   window_len;
      logic [31:0]        volt_gain;
      logic [31:0]        temp_offset;
      logic [31:0]        temp_gain;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic clear_wr;
      logic reb_start;
      logic reb_read;
      logic item_read;
      logic item_update;
      logic div_step;
      logic mul;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic reb_last;
   } status_type;

endpackage

// ----- design/adcema_if.sv -----
interface adcema_req_if #(
   parameter int SAMPLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic                   channel;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink (input valid, input channel, input sample, output ready);
endinterface

interface adcema_rsp_if #(
   parameter int SAMPLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic                   out_channel;
   logic [SAMPLE_BITS-1:0] smoothed;
   logic signed [31:0]     physical;

   modport source (output valid, output out_channel, output smoothed, output physical,
                   input ready);
   modport sink (input valid, input out_channel, input smoothed, input physical,
                 output ready);
endinterface

// ----- design/adcema_ram.sv -----
module adcema_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- design/adcema_csr.sv -----
module adcema_csr #(
   parameter int WINDOW_MAX = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [adcema_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [adcema_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [adcema_pkg::CSR_DATA_W-1:0]   prdata,
   output adcema_pkg::cfg_type                 cfg,
   output logic                                win_wr
);
   localparam int WIN_RESET = (WINDOW_MAX < adcema_pkg::WIN_RESET_MAX) ?
                              WINDOW_MAX : adcema_pkg::WIN_RESET_MAX;

   adcema_pkg::cfg_type cfg_ff, cfg_in;
   logic                                wr;
   logic [adcema_pkg::REG_IDX_W-1:0]    idx;
   logic [adcema_pkg::WIN_W-1:0]        win_raw;
   logic [adcema_pkg::WIN_W-1:0]        win_new;

   assign wr      = psel & penable & pwrite;
   assign idx     = paddr[adcema_pkg::CSR_ADDR_W-1:2];
   assign win_raw = pwdata[adcema_pkg::WIN_W-1:0];

   always_comb begin
      priority if (win_raw == '0) begin
         win_new = adcema_pkg::WIN_W'(1);
      end else if (int'(win_raw) > WINDOW_MAX) begin
         win_new = adcema_pkg::WIN_W'(WINDOW_MAX);
      end else begin
         win_new = win_raw;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      win_wr = 1'b0;
      if (wr) begin
         unique case (idx)
            adcema_pkg::REG_SHIFT_K: begin
               cfg_in.shift_k = pwdata[adcema_pkg::SHIFT_W-1:0];
            end
            adcema_pkg::REG_WINDOW_LEN: begin
               cfg_in.window_len = win_new;
               win_wr = 1'b1;
            end
            adcema_pkg::REG_VOLT_GAIN: begin
               cfg_in.volt_gain = pwdata;
            end
            adcema_pkg::REG_TEMP_OFFSET: begin
               cfg_in.temp_offset = pwdata;
            end
            adcema_pkg::REG_TEMP_GAIN: begin
               cfg_in.temp_gain = pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         adcema_pkg::REG_SHIFT_K:     prdata = 32'(cfg_ff.shift_k);
         adcema_pkg::REG_WINDOW_LEN:  prdata = 32'(cfg_ff.window_len);
         adcema_pkg::REG_VOLT_GAIN:   prdata = cfg_ff.volt_gain;
         adcema_pkg::REG_TEMP_OFFSET: prdata = cfg_ff.temp_offset;
         adcema_pkg::REG_TEMP_GAIN:   prdata = cfg_ff.temp_gain;
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shift_k     <= adcema_pkg::SHIFT_RESET;
         cfg_ff.window_len  <= adcema_pkg::WIN_W'(WIN_RESET);
         cfg_ff.volt_gain   <= adcema_pkg::VOLT_GAIN_RESET;
         cfg_ff.temp_offset <= '0;
         cfg_ff.temp_gain   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// ----- design/adcema_ctrl.sv -----
module adcema_ctrl #(
   parameter int DIV_STEPS = 19
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   win_wr,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   input  adcema_pkg::status_type status,
   output adcema_pkg::cmd_type    cmd
);
   localparam int DCNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_REBUILD,
      S_DRAIN,
      S_READ,
      S_UPDATE,
      S_DIVIDE,
      S_MULT,
      S_WRITE
   } state_type;

   state_type          state_ff, state_in;
   logic               pending_ff, pending_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DCNT_W-1:0]  div_cnt_ff, div_cnt_in;

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      div_cnt_in   = div_cnt_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (pending_ff) begin
               cmd.reb_start = 1'b1;
               pending_in    = 1'b0;
               state_in      = S_REBUILD;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_REBUILD: begin
            cmd.reb_read = 1'b1;
            if (status.reb_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         S_READ: begin
            cmd.item_read = 1'b1;
            state_in      = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.item_update = 1'b1;
            div_cnt_in      = '0;
            state_in        = S_DIVIDE;
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = S_MULT;
            end else begin
               div_cnt_in = div_cnt_ff + DCNT_W'(1);
            end
         end
         S_MULT: begin
            cmd.mul  = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (win_wr) begin
         pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pending_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ----- design/adcema_dp.sv -----
module adcema_dp #(
   parameter int NUM_CHANNELS = 2,
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_BITS  = 12,
   parameter int SUM_W        = 18,
   parameter int DIV_W        = 19
) (
   input  logic                    clock,
   input  logic                    reset,
   input  adcema_pkg::cmd_type     cmd,
   output adcema_pkg::status_type  status,
   input  adcema_pkg::cfg_type     cfg,
   input  logic                    req_channel,
   input  logic [SAMPLE_BITS-1:0]  req_sample,
   output logic                    rsp_out_channel,
   output logic [SAMPLE_BITS-1:0]  rsp_smoothed,
   output logic signed [31:0]      rsp_physical
);
   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int ADDR_W = CH_W + IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int ACC_W  = SAMPLE_BITS + adcema_pkg::ACC_HEADROOM;
   localparam int LEN_W  = adcema_pkg::WIN_W;
   localparam int PROD_W = SAMPLE_BITS + 34;
   localparam int DIFF_W = PROD_W + 1;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
   localparam logic [SAMPLE_BITS-1:0] TEMP_START =
      SAMPLE_BITS'(adcema_pkg::TEMP_START_LEVEL);
   localparam logic [ACC_W-1:0] ACC_TEMP_START =
      ACC_W'(TEMP_START) << adcema_pkg::ACC_RESET_SHIFT;

   logic [CH_W-1:0]        ch_ff, ch_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [ACC_W-1:0]       acc_ff [NUM_CHANNELS];
   logic [ACC_W-1:0]       acc_in [NUM_CHANNELS];
   logic [IDX_W-1:0]       ptr_ff [NUM_CHANNELS];
   logic [IDX_W-1:0]       ptr_in [NUM_CHANNELS];
   logic [SUM_W-1:0]       sum_ff [NUM_CHANNELS];
   logic [SUM_W-1:0]       sum_in [NUM_CHANNELS];
   logic [SAMPLE_BITS-1:0] filt_ff, filt_in;
   logic [CH_W-1:0]        sweep_ch_ff, sweep_ch_in;
   logic [IDX_W-1:0]       sweep_idx_ff, sweep_idx_in;
   logic                   reb_add_ff;
   logic [CH_W-1:0]        reb_ch_ff;
   logic [DIV_W-1:0]       quo_ff, quo_in;
   logic [LEN_W-1:0]       rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                   out_channel_ff, out_channel_in;
   logic [SAMPLE_BITS-1:0] smoothed_ff, smoothed_in;
   logic [31:0]            physical_ff, physical_in;

   logic [CH_W-1:0]        req_ch_eff;
   logic [ACC_W-1:0]       acc_cur;
   logic [ACC_W:0]         acc_sum;
   logic [ACC_W-1:0]       acc_new;
   logic [ACC_W-1:0]       filt_wide;
   logic [IDX_W-1:0]       ptr_cur;
   logic                   in_window;
   logic                   ptr_wrap;
   logic [SUM_W-1:0]       sum_cur;
   logic [SUM_W-1:0]       sum_upd;
   logic [DIV_W-1:0]       dividend;
   logic                   reb_idx_last;
   logic [ADDR_W-1:0]      sweep_addr;
   logic [ADDR_W-1:0]      item_addr;
   logic [ADDR_W-1:0]      sweep_next;
   logic [LEN_W:0]         rem_sh;
   logic [LEN_W:0]         rem_sub;
   logic                   q_bit;
   logic [SAMPLE_BITS-1:0] mean_new;
   logic signed [32:0]     gain_s;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-32:0]     diff_hi;
   logic [31:0]            phys_volt;
   logic [31:0]            phys_temp;

   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr;
   logic [SAMPLE_BITS-1:0] ram_wdata;
   logic [ADDR_W-1:0]      ram_raddr;
   logic [SAMPLE_BITS-1:0] ram_rdata;

   adcema_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ch_eff = (int'(req_channel) >= NUM_CHANNELS) ?
                       CH_W'(NUM_CHANNELS - 1) : CH_W'(req_channel);

   // recursive low-pass
   assign acc_cur   = acc_ff[ch_ff];
   assign acc_sum   = {1'b0, acc_cur} - {1'b0, acc_cur >> cfg.shift_k}
                      + (ACC_W + 1)'(sample_ff);
   assign acc_new   = acc_sum[ACC_W-1:0];
   assign filt_wide = acc_new >> cfg.shift_k;

   always_comb begin
      if (filt_wide > ACC_W'(SAMPLE_MAX)) begin
         filt_in = SAMPLE_MAX;
      end else begin
         filt_in = filt_wide[SAMPLE_BITS-1:0];
      end
      if (!cmd.item_read) begin
         filt_in = filt_ff;
      end
   end

   // ring pointer and running sum
   assign ptr_cur   = ptr_ff[ch_ff];
   assign in_window = int'(ptr_cur) < int'(cfg.window_len);
   assign ptr_wrap  = (int'(ptr_cur) + 1 >= int'(cfg.window_len)) ||
                      (int'(ptr_cur) + 1 >= WINDOW_MAX);
   assign item_addr = {ch_ff, ptr_cur};
   assign sum_cur   = sum_ff[ch_ff];
   assign sum_upd   = in_window ?
                      (sum_cur - SUM_W'(ram_rdata) + SUM_W'(filt_ff)) : sum_cur;
   assign dividend  = DIV_W'(sum_upd) + DIV_W'(cfg.window_len >> 1);

   // clear and rebuild sweep
   assign sweep_addr   = {sweep_ch_ff, sweep_idx_ff};
   assign sweep_next   = sweep_addr + ADDR_W'(1);
   assign reb_idx_last = (int'(sweep_idx_ff) + 1 >= int'(cfg.window_len)) ||
                         (int'(sweep_idx_ff) + 1 >= WINDOW_MAX);
   assign status.clear_last = &sweep_addr;
   assign status.reb_last   = reb_idx_last && (int'(sweep_ch_ff) >= NUM_CHANNELS - 1);

   always_comb begin
      sweep_ch_in  = sweep_ch_ff;
      sweep_idx_in = sweep_idx_ff;
      priority if (cmd.reb_start) begin
         sweep_ch_in  = '0;
         sweep_idx_in = '0;
      end else if (cmd.clear_wr) begin
         {sweep_ch_in, sweep_idx_in} = sweep_next;
      end else if (cmd.reb_read) begin
         if (reb_idx_last) begin
            sweep_idx_in = '0;
            sweep_ch_in  = sweep_ch_ff + CH_W'(1);
         end else begin
            sweep_idx_in = sweep_idx_ff + IDX_W'(1);
         end
      end else begin
      end
   end

   assign ram_we    = cmd.clear_wr | cmd.item_update;
   assign ram_waddr = cmd.clear_wr ? sweep_addr : item_addr;
   assign ram_wdata = cmd.clear_wr ? ((sweep_ch_ff == '0) ? '0 : TEMP_START) : filt_ff;
   assign ram_raddr = cmd.reb_read ? sweep_addr : item_addr;

   always_comb begin
      acc_in = acc_ff;
      ptr_in = ptr_ff;
      sum_in = sum_ff;
      if (cmd.item_read) begin
         acc_in[ch_ff] = acc_new;
      end
      if (cmd.reb_start) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            sum_in[c] = '0;
         end
      end else if (reb_add_ff) begin
         sum_in[reb_ch_ff] = sum_ff[reb_ch_ff] + SUM_W'(ram_rdata);
      end else begin
      end
      if (cmd.item_update) begin
         sum_in[ch_ff] = sum_upd;
         ptr_in[ch_ff] = ptr_wrap ? '0 : ptr_cur + IDX_W'(1);
      end
   end

   // restoring divide, one quotient bit per step
   assign rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_sub = rem_sh - {1'b0, cfg.window_len};
   assign q_bit   = rem_sh >= {1'b0, cfg.window_len};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.item_update) begin
         quo_in = dividend;
         rem_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[DIV_W-2:0], q_bit};
         rem_in = q_bit ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      end else begin
      end
   end

   assign mean_new = (quo_ff > DIV_W'(SAMPLE_MAX)) ? SAMPLE_MAX : quo_ff[SAMPLE_BITS-1:0];
   assign gain_s   = (ch_ff == '0) ? signed'({1'b0, cfg.volt_gain}) :
                     signed'({cfg.temp_gain[31], cfg.temp_gain});

   always_comb begin
      mean_in = mean_ff;
      prod_in = prod_ff;
      if (cmd.mul) begin
         mean_in = mean_new;
         prod_in = PROD_W'(signed'({1'b0, mean_new})) * PROD_W'(gain_s);
      end
   end

   // saturation to signed 32 bits
   assign phys_volt = (prod_ff[PROD_W-1:31] == '0) ? prod_ff[31:0] : adcema_pkg::PHYS_MAX;
   assign diff      = DIFF_W'(signed'(cfg.temp_offset)) - DIFF_W'(prod_ff);
   assign diff_hi   = diff[DIFF_W-1:31];

   always_comb begin
      if ((diff_hi == '0) || (diff_hi == '1)) begin
         phys_temp = diff[31:0];
      end else if (diff[DIFF_W-1]) begin
         phys_temp = adcema_pkg::PHYS_MIN;
      end else begin
         phys_temp = adcema_pkg::PHYS_MAX;
      end
   end

   always_comb begin
      ch_in          = ch_ff;
      sample_in      = sample_ff;
      out_channel_in = out_channel_ff;
      smoothed_in    = smoothed_ff;
      physical_in    = physical_ff;
      if (cmd.load) begin
         ch_in     = req_ch_eff;
         sample_in = req_sample;
      end
      if (cmd.out_load) begin
         out_channel_in = ch_ff[0];
         smoothed_in    = mean_ff;
         physical_in    = (ch_ff == '0) ? phys_volt : phys_temp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            acc_ff[c] <= (c == 0) ? '0 : ACC_TEMP_START;
            ptr_ff[c] <= '0;
            sum_ff[c] <= '0;
         end
         sweep_ch_ff  <= '0;
         sweep_idx_ff <= '0;
         reb_add_ff   <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         ptr_ff       <= ptr_in;
         sum_ff       <= sum_in;
         sweep_ch_ff  <= sweep_ch_in;
         sweep_idx_ff <= sweep_idx_in;
         reb_add_ff   <= cmd.reb_read;
      end
   end

   always_ff @(posedge clock) begin
      reb_ch_ff      <= sweep_ch_ff;
      ch_ff          <= ch_in;
      sample_ff      <= sample_in;
      filt_ff        <= filt_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      mean_ff        <= mean_in;
      prod_ff        <= prod_in;
      out_channel_ff <= out_channel_in;
      smoothed_ff    <= smoothed_in;
      physical_ff    <= physical_in;
   end

   assign rsp_out_channel = out_channel_ff;
   assign rsp_smoothed    = smoothed_ff;
   assign rsp_physical    = signed'(physical_ff);
endmodule

// ----- design/adc_exp_then_moving_average.sv -----
// Sequence: an accepted transaction passes the read, update, divide (by window_len,
// one quotient bit per cycle), multiply and write states. No new one is accepted until
// its result is registered; that write waits while the last result is not yet taken.
// Reset: synchronous; all 2**(CH_W + IDX_W) ring memory entries (128) are then swept,
// followed by a running-sum rebuild over window_len entries per channel; a write
// of window_len starts the same rebuild. No transaction is accepted during either.
module adc_exp_then_moving_average #(
   parameter int NUM_CHANNELS = 2,
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   adcema_req_if.sink                         req_bus,
   adcema_rsp_if.source                       rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [adcema_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [adcema_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [adcema_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                               csr_pready
);
   localparam int WIN_EFF = (WINDOW_MAX < adcema_pkg::WIN_LIMIT) ?
                            WINDOW_MAX : adcema_pkg::WIN_LIMIT;
   localparam int SUM_W   = $clog2(WIN_EFF * ((1 << SAMPLE_BITS) - 1) + 1);
   localparam int DIV_W   = SUM_W + 1;

   adcema_pkg::cfg_type    cfg;
   adcema_pkg::cmd_type    cmd;
   adcema_pkg::status_type status;
   logic                   win_wr;
   logic                   req_ready;
   logic                   rsp_valid;

   assign csr_pready = 1'b1;

   adcema_csr #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg),
      .win_wr  (win_wr)
   );

   adcema_ctrl #(
      .DIV_STEPS (DIV_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .win_wr    (win_wr),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   adcema_dp #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .SUM_W        (SUM_W),
      .DIV_W        (DIV_W)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cfg             (cfg),
      .req_channel     (req_bus.channel),
      .req_sample      (req_bus.sample),
      .rsp_out_channel (rsp_bus.out_channel),
      .rsp_smoothed    (rsp_bus.smoothed),
      .rsp_physical    (rsp_bus.physical)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;
endmodule

// ----- verif/tb_adc_exp_then_moving_average.sv -----
`timescale 1ns / 100ps

module tb_adc_exp_then_moving_average;

   localparam int CLK_PERIOD      = 20;
   localparam int NUM_CH          = 2;
   localparam int WIN_MAX         = 64;
   localparam int SAMPLE_W        = 12;
   localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = '1;
   localparam int CLEAR_CYCLES    = 128;
   localparam int REBUILD_CYCLES  = NUM_CH * WIN_MAX + 2;
   localparam int SETTLE_CYCLES   = CLEAR_CYCLES + REBUILD_CYCLES + 40;
   localparam int TAIL_CYCLES     = 60;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int TIMEOUT_CYCLES  = 400_000;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 140;

   localparam logic [adcema_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [adcema_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   localparam logic CH_VOLT = 1'b0;
   localparam logic CH_TEMP = 1'b1;

   typedef struct packed {
      logic                out_channel;
      logic [SAMPLE_W-1:0] smoothed;
      logic signed [31:0]  physical;
   } reading_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [adcema_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [adcema_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [adcema_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                              csr_pready;

   adcema_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_bus ();
   adcema_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_bus ();

   adc_exp_then_moving_average #(
      .NUM_CHANNELS (NUM_CH),
      .WINDOW_MAX   (WIN_MAX),
      .SAMPLE_BITS  (SAMPLE_W)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // filter model state and register copies
   logic [adcema_pkg::SHIFT_W-1:0] shift_cfg;
   int unsigned         win_cfg;
   logic [31:0]         volt_gain_cfg;
   logic signed [31:0]  temp_offset_cfg;
   logic signed [31:0]  temp_gain_cfg;
   logic [31:0]         filt_accum [NUM_CH];
   logic [SAMPLE_W-1:0] ring_levels [NUM_CH][WIN_MAX];
   int unsigned         ring_ptr [NUM_CH];
   logic [31:0]         ring_total [NUM_CH];

   reading_type expected_readings [$];

   int error_count     = 0;
   int checked_count   = 0;
   int sent_count      = 0;
   int csr_write_count = 0;
   int hold_off_cycles = 0;
   bit idle_enable     = 1'b1;

   always begin
      clock = 1'b0;
      #(CLK_PERIOD / 2);
      clock = 1'b1;
      #(CLK_PERIOD / 2);
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
   endtask

   function automatic void resum_windows();
      for (int c = 0; c < NUM_CH; c++) begin
         ring_total[c] = '0;
         for (int i = 0; i < win_cfg; i++) ring_total[c] += 32'(ring_levels[c][i]);
      end
   endfunction

   function automatic reading_type predict_reading(input logic ch,
                                                   input logic [SAMPLE_W-1:0] smp);
      reading_type        r;
      int                 c;
      int unsigned        p;
      logic [31:0]        acc;
      logic [31:0]        level;
      logic [31:0]        mean;
      logic [63:0]        volts;
      logic signed [63:0] temp;
      logic signed [63:0] mean_s;
      logic signed [63:0] off_s;
      logic signed [63:0] gain_s;
      c = int'(ch);
      acc = filt_accum[c] - (filt_accum[c] >> shift_cfg) + 32'(smp);
      filt_accum[c] = acc;
      level = acc >> shift_cfg;
      if (level > 32'(SAMPLE_TOP)) level = 32'(SAMPLE_TOP);
      // a pointer past a shortened window stores but does not count
      p = ring_ptr[c];
      if (p < win_cfg) ring_total[c] = ring_total[c] - 32'(ring_levels[c][p]) + level;
      ring_levels[c][p] = level[SAMPLE_W-1:0];
      p = p + 1;
      ring_ptr[c] = (p >= win_cfg) ? 0 : p;
      mean = (ring_total[c] + (win_cfg >> 1)) / win_cfg;
      if (mean > 32'(SAMPLE_TOP)) mean = 32'(SAMPLE_TOP);
      r.out_channel = ch;
      r.smoothed = mean[SAMPLE_W-1:0];
      if (ch == CH_VOLT) begin
         volts = {32'd0, mean} * {32'd0, volt_gain_cfg};
         r.physical = (volts > 64'(adcema_pkg::PHYS_MAX)) ? adcema_pkg::PHYS_MAX :
                      volts[31:0];
      end else begin
         mean_s = {32'd0, mean};
         off_s = 64'(temp_offset_cfg);
         gain_s = 64'(temp_gain_cfg);
         temp = off_s - mean_s * gain_s;
         if (temp > 64'sd2147483647) r.physical = adcema_pkg::PHYS_MAX;
         else if (temp < -64'sd2147483648) r.physical = adcema_pkg::PHYS_MIN;
         else r.physical = temp[31:0];
      end
      return r;
   endfunction

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_readings.size() != 0);
   endtask

   task automatic send_sample(input logic ch, input logic [SAMPLE_W-1:0] smp);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.channel <= ch;
      req_bus.sample <= smp;
      do @(posedge clock); while (!req_bus.ready);
      expected_readings.push_back(predict_reading(ch, smp));
      sent_count++;
   endtask

   task automatic csr_write(input logic [adcema_pkg::REG_IDX_W-1:0] idx,
                            input logic [31:0] value);
      int unsigned n;
      wait_for_results();
      // covers the post-reset clear and any running-sum rebuild
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_write_count++;
      case (idx)
         adcema_pkg::REG_SHIFT_K: shift_cfg = value[adcema_pkg::SHIFT_W-1:0];
         adcema_pkg::REG_WINDOW_LEN: begin
            n = 32'(value[adcema_pkg::WIN_W-1:0]);
            if (n == 0) n = 1;
            if (n > WIN_MAX) n = WIN_MAX;
            win_cfg = n;
            resum_windows();
         end
         adcema_pkg::REG_VOLT_GAIN: volt_gain_cfg = value;
         adcema_pkg::REG_TEMP_OFFSET: temp_offset_cfg = value;
         adcema_pkg::REG_TEMP_GAIN: temp_gain_cfg = value;
         default: ;
      endcase
   endtask

   function automatic logic [SAMPLE_W-1:0] draw_sample(input logic [SAMPLE_W-1:0] center);
      int v;
      case ($urandom_range(0, 9))
         0, 1: return SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
         2: return ($urandom_range(0, 1) != 0) ? SAMPLE_TOP : '0;
         default: begin
            v = int'(center) + int'($urandom_range(0, 128)) - 64;
            if (v < 0) v = 0;
            if (v > SAMPLE_TOP) v = SAMPLE_TOP;
            return v[SAMPLE_W-1:0];
         end
      endcase
   endfunction

   function automatic logic [31:0] draw_gain();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0010_0000);
         2: return 32'd0 - $urandom_range(0, 32'h0010_0000);
         default: return $urandom_range(0, 32'h0000_4000);
      endcase
   endfunction

   task automatic test_reset_levels();
      send_sample(CH_TEMP, SAMPLE_W'(adcema_pkg::TEMP_START_LEVEL));
      send_sample(CH_VOLT, SAMPLE_TOP);
      send_sample(CH_VOLT, '0);
   endtask

   // lowering the shift without rescaling pushes the filter output past full scale
   task automatic test_filter_saturation();
      csr_write(adcema_pkg::REG_SHIFT_K, 32'd2);
      send_sample(CH_TEMP, SAMPLE_TOP);
      send_sample(CH_TEMP, SAMPLE_TOP);
   endtask

   task automatic test_gain_extremes();
      csr_write(adcema_pkg::REG_WINDOW_LEN, 32'd1);
      csr_write(adcema_pkg::REG_SHIFT_K, 32'd0);
      csr_write(adcema_pkg::REG_VOLT_GAIN, 32'hFFFF_FFFF);
      csr_write(adcema_pkg::REG_TEMP_OFFSET, adcema_pkg::PHYS_MIN);
      csr_write(adcema_pkg::REG_TEMP_GAIN, adcema_pkg::PHYS_MAX);
      send_sample(CH_VOLT, '0);
      send_sample(CH_VOLT, SAMPLE_TOP);
      send_sample(CH_TEMP, '0);
      send_sample(CH_TEMP, SAMPLE_TOP);
      csr_write(adcema_pkg::REG_TEMP_OFFSET, adcema_pkg::PHYS_MAX);
      csr_write(adcema_pkg::REG_TEMP_GAIN, adcema_pkg::PHYS_MIN);
      send_sample(CH_TEMP, SAMPLE_TOP);
      csr_write(adcema_pkg::REG_VOLT_GAIN, 32'd0);
      send_sample(CH_VOLT, 12'hAAA);
      csr_write(adcema_pkg::REG_VOLT_GAIN, 32'd1);
      send_sample(CH_VOLT, 12'h555);
   endtask

   task automatic test_window_limits();
      csr_write(adcema_pkg::REG_WINDOW_LEN, 32'd0);
      send_sample(CH_TEMP, 12'h555);
      csr_write(adcema_pkg::REG_WINDOW_LEN, 32'd100);
      send_sample(CH_VOLT, 12'h0F0);
      csr_write(adcema_pkg::REG_WINDOW_LEN, 32'd127);
      send_sample(CH_TEMP, 12'hF0F);
   endtask

   task automatic test_short_window();
      csr_write(adcema_pkg::REG_WINDOW_LEN, WIN_MAX);
      for (int n = 0; n < 5; n++) begin
         send_sample(CH_VOLT, SAMPLE_W'($urandom_range(0, SAMPLE_TOP)));
      end
      csr_write(adcema_pkg::REG_WINDOW_LEN, 32'd3);
      send_sample(CH_VOLT, SAMPLE_TOP);
      send_sample(CH_VOLT, SAMPLE_TOP);
   endtask

   task automatic test_unmapped_registers();
      csr_write(REG_SPARE_LO, $urandom);
      csr_write(REG_SPARE_HI, $urandom);
      send_sample(CH_TEMP, SAMPLE_W'($urandom_range(0, SAMPLE_TOP)));
   endtask

   task automatic test_output_backpressure();
      idle_enable = 1'b0;
      hold_off_cycles = HOLD_OFF_CYCLES;
      for (int n = 0; n < 12; n++) begin
         send_sample(n[0], SAMPLE_W'($urandom_range(0, SAMPLE_TOP)));
      end
      wait_for_results();
   endtask

   task automatic test_random_phase(input int phase);
      logic [SAMPLE_W-1:0] centers [NUM_CH];
      logic                ch;
      idle_enable = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      csr_write(adcema_pkg::REG_SHIFT_K, (phase == 0) ? 32'd0 : (phase == 1) ? 32'd15 :
                $urandom_range(0, 15));
      csr_write(adcema_pkg::REG_WINDOW_LEN, (phase == 0) ? 32'd1 : (phase == 1) ? 32'd64 :
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) :
                $urandom_range(1, WIN_MAX));
      csr_write(adcema_pkg::REG_VOLT_GAIN, (phase == 2) ? 32'hFFFF_FFFF : draw_gain());
      csr_write(adcema_pkg::REG_TEMP_OFFSET, draw_gain());
      csr_write(adcema_pkg::REG_TEMP_GAIN, draw_gain());
      for (int c = 0; c < NUM_CH; c++) centers[c] = SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         ch = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 49) == 0) centers[ch] = SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
         send_sample(ch, draw_sample(centers[ch]));
         if ($urandom_range(0, 39) == 0) wait_for_results();
      end
   endtask

   // result side: random ready bursts plus the long hold-off
   initial begin : result_sink
      int burst;
      burst = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (burst > 0) begin
            burst--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 8) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      reading_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("unexpected transaction, smoothed", rsp_bus.smoothed, -1);
         end else begin
            want = expected_readings.pop_front();
            checked_count++;
            if (rsp_bus.out_channel !== want.out_channel)
               report_mismatch("out_channel", rsp_bus.out_channel, want.out_channel);
            if (rsp_bus.smoothed !== want.smoothed)
               report_mismatch("smoothed", rsp_bus.smoothed, want.smoothed);
            if (rsp_bus.physical !== want.physical)
               report_mismatch("physical", rsp_bus.physical, want.physical);
         end
      end
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.channel <= CH_VOLT;
      req_bus.sample <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      reset <= 1'b1;

      shift_cfg = adcema_pkg::SHIFT_RESET;
      win_cfg = adcema_pkg::WIN_RESET_MAX;
      volt_gain_cfg = adcema_pkg::VOLT_GAIN_RESET;
      temp_offset_cfg = '0;
      temp_gain_cfg = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         filt_accum[c] = 32'(((c == 0) ? 0 : adcema_pkg::TEMP_START_LEVEL)
                             << adcema_pkg::ACC_RESET_SHIFT);
         for (int i = 0; i < WIN_MAX; i++) begin
            ring_levels[c][i] = (c == 0) ? '0 : SAMPLE_W'(adcema_pkg::TEMP_START_LEVEL);
         end
         ring_ptr[c] = 0;
      end
      resum_windows();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_levels();
      test_filter_saturation();
      test_gain_extremes();
      test_window_limits();
      test_short_window();
      test_unmapped_registers();
      test_output_backpressure();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) test_random_phase(ph);

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d samples on both channels, %0d results checked, %0d csr writes",
               sent_count, checked_count, csr_write_count);
      $display("Windows 0..127, shifts 0..15, saturating gains, %0d-cycle output stall",
               HOLD_OFF_CYCLES);
      if (error_count == 0 && expected_readings.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Timeout with %0d results outstanding", expected_readings.size());
      $display("FAIL");
      $finish;
   end

endmodule
